// File: hdl/nf_pkg.sv
// ============================================================================
// nf_pkg: shared definitions for the notch filter
// Default sizes, register indexes and the control word of the shared adder.
// ============================================================================
`default_nettype none

package nf_pkg;

    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int OMEGA_FRAC_BITS_DEF = 16;
    localparam int OUT_FRAC_BITS_DEF   = 8;

    // Configuration register indexes.
    localparam int          CFG_IDX_BITS      = 1;
    localparam logic [0:0]  REG_OMEGA_DT      = 1'b0;
    localparam logic [0:0]  REG_INITIAL_VALUE = 1'b1;

    // Control of the shared add/subtract unit.
    typedef struct packed {
        logic sub;     // subtract b instead of adding it
        logic zero_a;  // force operand a to zero (negation)
    } t_alu_ctl;

endpackage

`default_nettype wire

// File: hdl/notch_filter.sv
// ============================================================================
// notch_filter: second-order IIR notch filter, fixed point
// One shared adder computes the numerator and denominator by shift-add and
// then divides them with a restoring divider, one bit per cycle.
// ============================================================================
// A request is accepted only in idle; the next one waits until the result has been
// written to the output register. Three shift-add multiplies and a restoring
// divide of SAMPLE_BITS+OUT_FRAC_BITS+5 steps share one adder.
// Reset (synchronous, active low) clears the sequencer, output valid, omega and history.
`default_nettype none

module notch_filter #(
    parameter int SAMPLE_BITS     = nf_pkg::SAMPLE_BITS_DEF,
    parameter int OMEGA_FRAC_BITS = nf_pkg::OMEGA_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = nf_pkg::OUT_FRAC_BITS_DEF,
    localparam int OMEGA_BITS     = OMEGA_FRAC_BITS + 2,
    localparam int CFG_W          = (OMEGA_BITS > SAMPLE_BITS) ? OMEGA_BITS : SAMPLE_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [nf_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]               i_cfg_wdata,
    // Sample requests
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_sample,
    // Filter results
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_filtered,
    output logic                                o_saturated
);

    localparam int WB   = OMEGA_BITS;
    localparam int HB   = SAMPLE_BITS + OUT_FRAC_BITS;
    localparam int AHW  = HB + 3;
    localparam int AW   = HB + 2 * OMEGA_FRAC_BITS + 6;
    localparam int DW   = 2 * OMEGA_FRAC_BITS + 5;
    localparam int RW   = DW + 1;
    localparam int QB   = HB + 5;
    localparam int MAXS = (WB > QB) ? WB : QB;
    localparam int CW   = $clog2(MAXS);
    localparam int WIX  = $clog2(WB);

    localparam logic [HB-1:0] HALF    = HB'((1 << OUT_FRAC_BITS) >> 1);
    localparam logic [DW-1:0] DEN_MIN = DW'(1) << (2 * OMEGA_FRAC_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEN  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_NUM  = 3'd3;
    localparam logic [2:0] S_ABS  = 3'd4;
    localparam logic [2:0] S_BIAS = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic [WB-1:0]          r_omega;
    logic [SAMPLE_BITS-1:0] r_x;
    logic [SAMPLE_BITS-1:0] r_x1;
    logic [SAMPLE_BITS-1:0] r_x2;
    logic [HB-1:0]          r_y1;
    logic [HB-1:0]          r_y2;
    logic [AW-1:0]          r_acc;
    logic [AW-1:0]          r_mcand;
    logic [DW-1:0]          r_den;
    logic [RW-1:0]          r_rem;
    logic [QB-1:0]          r_q;
    logic                   r_neg;
    logic [CW-1:0]          r_cnt;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_filtered;
    logic                   r_sat;

    // ---------------------------------------------------------------------
    // Operand preparation
    // ---------------------------------------------------------------------
    logic [HB-1:0]  w_xs_hb;
    logic [HB-1:0]  w_x1s_hb;
    logic [HB-1:0]  w_x2s_hb;
    logic [AHW-1:0] w_a;
    logic [AW-1:0]  w_den_init;
    logic [AW-1:0]  w_den_mcand;
    logic [AW-1:0]  w_upd_init;
    logic [AW-1:0]  w_upd_mcand;
    logic [AW-1:0]  w_num_init;
    logic [RW-1:0]  w_dv;
    logic [RW:0]    w_t;
    logic [HB-1:0]  w_init_y;

    assign w_xs_hb  = HB'(r_x) << OUT_FRAC_BITS;
    assign w_x1s_hb = HB'(r_x1) << OUT_FRAC_BITS;
    assign w_x2s_hb = HB'(r_x2) << OUT_FRAC_BITS;

    // Second-difference part of the numerator, scaled by S^2 later.
    assign w_a = ({{3{r_y1[HB-1]}}, r_y1} << 1)
               - {{3{r_y2[HB-1]}}, r_y2}
               + {{3{w_xs_hb[HB-1]}}, w_xs_hb}
               - ({{3{w_x1s_hb[HB-1]}}, w_x1s_hb} << 1)
               + {{3{w_x2s_hb[HB-1]}}, w_x2s_hb};

    // Each multiply runs MSB first over omega, so the start value of the
    // accumulator comes out scaled by 2^(OMEGA_FRAC_BITS+2). The numerator
    // is built doubled to keep every start value an integer.
    assign w_den_init  = AW'(1) << (OMEGA_FRAC_BITS - 2);
    assign w_den_mcand = (AW'(1) << (OMEGA_FRAC_BITS + 1)) + AW'(r_omega);
    assign w_upd_init  = {{(AW-HB){r_y1[HB-1]}}, r_y1};
    assign w_upd_mcand = {{(AW-SAMPLE_BITS){r_x[SAMPLE_BITS-1]}}, r_x} << (OUT_FRAC_BITS + 1);
    assign w_num_init  = {{(AW-AHW){w_a[AHW-1]}}, w_a} << (OMEGA_FRAC_BITS - 1);

    assign w_dv     = {r_den, 1'b0};
    assign w_t      = {r_rem, r_q[QB-1]};
    assign w_init_y = HB'(i_cfg_wdata[SAMPLE_BITS-1:0]) << OUT_FRAC_BITS;

    // ---------------------------------------------------------------------
    // Shared adder
    // ---------------------------------------------------------------------
    nf_pkg::t_alu_ctl w_alu_ctl;
    logic [AW-1:0]    w_alu_a;
    logic [AW-1:0]    w_alu_b;
    logic [AW-1:0]    w_alu;
    logic             w_ge;

    always_comb begin
        w_alu_ctl = '0;
        w_alu_a   = {r_acc[AW-2:0], 1'b0};
        w_alu_b   = r_omega[r_cnt[WIX-1:0]] ? r_mcand : '0;
        case (r_state)
            S_ABS: begin
                w_alu_ctl.sub    = 1'b1;
                w_alu_ctl.zero_a = 1'b1;
                w_alu_a          = r_acc;
                w_alu_b          = r_acc;
            end
            S_BIAS: begin
                w_alu_a = r_acc;
                w_alu_b = AW'(r_den);
            end
            S_DIV: begin
                w_alu_ctl.sub = 1'b1;
                w_alu_a       = AW'(w_t);
                w_alu_b       = AW'(w_dv);
            end
            default: begin
            end
        endcase
    end

    nf_alu #(
        .W (AW)
    ) u_alu (
        .i_ctl (w_alu_ctl),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_sum (w_alu)
    );

    assign w_ge = ~w_alu[AW-1];

    // ---------------------------------------------------------------------
    // Clipping and final rounding
    // ---------------------------------------------------------------------
    logic [QB-1:0]          w_lim;
    logic                   w_over1;
    logic [HB-1:0]          w_m2;
    logic [HB-1:0]          w_rs;
    logic [SAMPLE_BITS-1:0] w_rmag;
    logic [SAMPLE_BITS-1:0] w_lim2;
    logic                   w_over2;
    logic [SAMPLE_BITS-1:0] w_m3;
    logic [SAMPLE_BITS-1:0] w_res;
    logic [HB-1:0]          w_y;
    logic                   w_fin;

    assign w_lim   = r_neg ? (QB'(1) << (HB - 1)) : ((QB'(1) << (HB - 1)) - QB'(1));
    assign w_over1 = r_q > w_lim;
    assign w_m2    = w_over1 ? w_lim[HB-1:0] : r_q[HB-1:0];
    assign w_y     = r_neg ? (HB'(0) - w_m2) : w_m2;
    assign w_rs    = w_m2 + HALF;
    assign w_rmag  = w_rs[HB-1 -: SAMPLE_BITS];
    assign w_lim2  = r_neg ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    assign w_over2 = w_rmag > w_lim2;
    assign w_m3    = w_over2 ? w_lim2 : w_rmag;
    assign w_res   = r_neg ? (SAMPLE_BITS'(0) - w_m3) : w_m3;

    assign w_fin   = (r_state == S_FIN) && (!r_out_valid || i_ready);

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_DEN;
            S_DEN:  if (r_cnt == '0) n_state = S_UPD;
            S_UPD:  if (r_cnt == '0) n_state = S_NUM;
            S_NUM:  if (r_cnt == '0) n_state = S_ABS;
            S_ABS:  n_state = S_BIAS;
            S_BIAS: n_state = S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_FIN;
            S_FIN:  if (w_fin) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_omega     <= '0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
        end else begin
            r_state <= n_state;
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    nf_pkg::REG_OMEGA_DT: begin
                        r_omega <= i_cfg_wdata[WB-1:0];
                    end
                    nf_pkg::REG_INITIAL_VALUE: begin
                        r_x1 <= i_cfg_wdata[SAMPLE_BITS-1:0];
                        r_x2 <= i_cfg_wdata[SAMPLE_BITS-1:0];
                        r_y1 <= w_init_y;
                        r_y2 <= w_init_y;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_fin) begin
                r_x2 <= r_x1;
                r_x1 <= r_x;
                r_y2 <= r_y1;
                r_y1 <= w_y;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_x     <= i_sample;
                    r_acc   <= w_den_init;
                    r_mcand <= w_den_mcand;
                    r_cnt   <= CW'(WB - 1);
                end
            end
            S_DEN: begin
                if (r_cnt == '0) begin
                    r_den   <= w_alu[DW-1:0];
                    r_acc   <= w_upd_init;
                    r_mcand <= w_upd_mcand;
                    r_cnt   <= CW'(WB - 1);
                end else begin
                    r_acc <= w_alu;
                    r_cnt <= r_cnt - CW'(1);
                end
            end
            S_UPD: begin
                if (r_cnt == '0) begin
                    r_mcand <= w_alu;
                    r_acc   <= w_num_init;
                    r_cnt   <= CW'(WB - 1);
                end else begin
                    r_acc <= w_alu;
                    r_cnt <= r_cnt - CW'(1);
                end
            end
            S_NUM: begin
                r_acc <= w_alu;
                r_cnt <= r_cnt - CW'(1);
            end
            S_ABS: begin
                r_neg <= r_acc[AW-1];
                if (r_acc[AW-1]) begin
                    r_acc <= w_alu;
                end
            end
            S_BIAS: begin
                // Twice the numerator magnitude plus the denominator, divided
                // by twice the denominator, rounds half away from zero.
                r_rem <= RW'(w_alu[AW-1:QB]);
                r_q   <= w_alu[QB-1:0];
                r_cnt <= CW'(QB - 1);
            end
            S_DIV: begin
                r_rem <= w_ge ? w_alu[RW-1:0] : w_t[RW-1:0];
                r_q   <= {r_q[QB-2:0], w_ge};
                r_cnt <= r_cnt - CW'(1);
            end
            S_FIN: begin
                if (w_fin) begin
                    r_filtered <= w_res;
                    r_sat      <= w_over1 | w_over2;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_filtered  = r_filtered;
    assign o_saturated = r_sat;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_den_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_den >= DEN_MIN))
        else $error("denominator below S^2");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < w_dv))
        else $error("divider remainder out of range");

    a_mul_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEN || r_state == S_UPD || r_state == S_NUM)
        |-> (r_cnt <= CW'(WB - 1)))
        else $error("multiply step count out of range");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside the final step");

endmodule

`default_nettype wire

// File: hdl/nf_alu.sv
// ============================================================================
// nf_alu: shared add/subtract unit
// One wide two's complement adder used for multiply steps, negation, rounding
// bias and the restoring divide.
// ============================================================================
`default_nettype none

module nf_alu #(
    parameter int W = 62
) (
    input  wire nf_pkg::t_alu_ctl i_ctl,
    input  wire logic [W-1:0]     i_a,
    input  wire logic [W-1:0]     i_b,
    output logic [W-1:0]          o_sum
);

    logic [W-1:0] w_a;

    assign w_a   = i_ctl.zero_a ? '0 : i_a;
    assign o_sum = i_ctl.sub ? (w_a - i_b) : (w_a + i_b);

endmodule

`default_nettype wire
